FILE: sv/raised_cosine_membership_assert.svh
// ----------------------------------------------------------------------------
// Raised-cosine membership assertion macros
// Concurrent check macros used by the raised-cosine membership block.
// ----------------------------------------------------------------------------
`ifndef RAISED_COSINE_MEMBERSHIP_ASSERT_SVH
`define RAISED_COSINE_MEMBERSHIP_ASSERT_SVH
`ifndef SYNTH
// Overlapping implication: cons must hold in the same cycle as ante.
`define RCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcm: assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define RCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcm: assertion failed");
`else
`define RCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/rcm_pkg.sv
// ----------------------------------------------------------------------------
// Raised-cosine membership package
// Shared widths, register codes, fixed-point constants and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package rcm_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned DEGREE_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_DATA_W-1:0] CENTER_RST = 16'd0;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 16'd256;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 16'd32768;
    localparam logic [CFG_DATA_W-1:0] WIDTH_MIN  = 16'd1;

    // Phase resolution and divider widths.
    localparam int unsigned PHASE_BITS = 12;
    localparam int unsigned DIV_DEN_W  = 17;
    localparam int unsigned DIV_NUM_W  = PHASE_BITS + DIV_DEN_W;
    localparam logic [PHASE_BITS-1:0] QUOT_MAX = PHASE_BITS'(1) << (PHASE_BITS - 1);

    // Angle and cosine widths, Q2.30.
    localparam int unsigned THETA_W      = 31;
    localparam int unsigned THETA_PROD_W = 32 + PHASE_BITS;
    localparam int unsigned X2_W         = 32;
    localparam int unsigned COS_W        = 31;
    localparam int unsigned Q30_SHIFT    = 30;
    localparam int unsigned DEG_PROD_W   = 48;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [COS_W-1:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [COS_W-1:0] HALF_Q30 = 31'h2000_0000;

    // Horner steps of the cosine series: divisors, reciprocal shifts and
    // reciprocals. The reciprocal estimate is at most one below the quotient.
    localparam int unsigned HORNER_STEPS = 7;
    localparam int unsigned HORNER_STAGES = 3 * HORNER_STEPS;
    localparam int unsigned REM_W = 10;
    localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12, 2};
    localparam int unsigned HORNER_SHIFT [HORNER_STEPS] = '{
        31 + $clog2(182), 31 + $clog2(132), 31 + $clog2(90), 31 + $clog2(56),
        31 + $clog2(30), 31 + $clog2(12), 31 + $clog2(2)
    };
    localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
        32'((64'd1 << (31 + $clog2(182))) / 64'd182),
        32'((64'd1 << (31 + $clog2(132))) / 64'd132),
        32'((64'd1 << (31 + $clog2(90))) / 64'd90),
        32'((64'd1 << (31 + $clog2(56))) / 64'd56),
        32'((64'd1 << (31 + $clog2(30))) / 64'd30),
        32'((64'd1 << (31 + $clog2(12))) / 64'd12),
        32'((64'd1 << (31 + $clog2(2))) / 64'd2)
    };

    // Divider request and result.
    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic                 outside;
    } t_div_in;

    typedef struct packed {
        logic [PHASE_BITS-1:0] quot;
        logic                  outside;
    } t_div_out;

    // Cosine request and result.
    typedef struct packed {
        logic [X2_W-1:0] x2;
        logic            outside;
    } t_cos_in;

    typedef struct packed {
        logic [COS_W-1:0] c;
        logic             outside;
    } t_cos_out;

endpackage

`default_nettype wire

FILE: sv/rcm_if.sv
// ----------------------------------------------------------------------------
// Raised-cosine membership channel interfaces
// Valid/ready channels for samples, degrees and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcm_sample_if;
    import rcm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface rcm_degree_if;
    import rcm_pkg::*;
    logic                valid;
    logic                ready;
    logic [DEGREE_W-1:0] degree;
    modport source (output valid, output degree, input ready);
    modport sink (input valid, input degree, output ready);
endinterface

interface rcm_cfg_if;
    import rcm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/rcm_div.sv
// ----------------------------------------------------------------------------
// Raised-cosine membership phase divider
// Restoring divider with one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  rcm_pkg::t_div_in   i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output rcm_pkg::t_div_out  o_out_data
);
    import rcm_pkg::*;

    logic [PHASE_BITS-1:0] r_vld;
    logic [PHASE_BITS:0]   stg_rdy;
    logic [DIV_DEN_W-1:0]  r_rem  [PHASE_BITS];
    logic [PHASE_BITS-1:0] r_nlow [PHASE_BITS];
    logic [DIV_DEN_W-1:0]  r_den  [PHASE_BITS];
    logic [PHASE_BITS-1:0] r_quot [PHASE_BITS];
    logic [PHASE_BITS-1:0] r_tag;

    // A stage takes a new request when it is empty or its successor moves.
    assign stg_rdy[PHASE_BITS] = i_out_ready;
    assign o_in_ready = stg_rdy[0];

    for (genvar s = 0; s < PHASE_BITS; s++) begin : g_stage
        logic                  vld_in;
        logic [DIV_DEN_W-1:0]  rem_in;
        logic [PHASE_BITS-1:0] nlow_in;
        logic [DIV_DEN_W-1:0]  den_in;
        logic [PHASE_BITS-1:0] quot_in;
        logic                  tag_in;
        logic [DIV_DEN_W:0]    trial;
        logic [DIV_DEN_W:0]    diff;
        logic                  ge;
        logic [DIV_DEN_W-1:0]  n_rem;

        assign stg_rdy[s] = !r_vld[s] || stg_rdy[s+1];

        // The first stage loads the upper numerator bits as partial remainder.
        if (s == 0) begin : g_first
            assign vld_in  = i_in_valid;
            assign rem_in  = i_in_data.num[DIV_NUM_W-1:PHASE_BITS];
            assign nlow_in = i_in_data.num[PHASE_BITS-1:0];
            assign den_in  = i_in_data.den;
            assign quot_in = '0;
            assign tag_in  = i_in_data.outside;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign nlow_in = r_nlow[s-1];
            assign den_in  = r_den[s-1];
            assign quot_in = r_quot[s-1];
            assign tag_in  = r_tag[s-1];
        end

        // Shift in the next numerator bit and subtract the divisor if it fits.
        assign trial = {rem_in, nlow_in[PHASE_BITS-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};
        assign n_rem = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (stg_rdy[s]) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_rdy[s] && vld_in) begin
                r_rem[s]  <= n_rem;
                r_nlow[s] <= {nlow_in[PHASE_BITS-2:0], 1'b0};
                r_den[s]  <= den_in;
                r_quot[s] <= {quot_in[PHASE_BITS-2:0], ge};
                r_tag[s]  <= tag_in;
            end
        end
    end

    assign o_out_valid        = r_vld[PHASE_BITS-1];
    assign o_out_data.quot    = r_quot[PHASE_BITS-1];
    assign o_out_data.outside = r_tag[PHASE_BITS-1];

endmodule

`default_nettype wire

FILE: sv/rcm_cos.sv
// ----------------------------------------------------------------------------
// Raised-cosine membership cosine pipeline
// Horner evaluation of the cosine series, three pipeline stages per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_cos (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  rcm_pkg::t_cos_in   i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output rcm_pkg::t_cos_out  o_out_data
);
    import rcm_pkg::*;

    logic [HORNER_STAGES-1:0] r_vld;
    logic [HORNER_STAGES:0]   stg_rdy;
    logic [HORNER_STAGES-1:0] r_tag;
    logic [X2_W-1:0]          r_x2   [HORNER_STAGES];
    logic [31:0]              r_a_p  [HORNER_STEPS];
    logic [31:0]              r_b_p  [HORNER_STEPS];
    logic [31:0]              r_b_qe [HORNER_STEPS];
    logic [COS_W-1:0]         r_c_r  [HORNER_STEPS];

    assign stg_rdy[HORNER_STAGES] = i_out_ready;
    assign o_in_ready = stg_rdy[0];

    for (genvar k = 0; k < HORNER_STAGES; k++) begin : g_rdy
        assign stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
    end

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
        localparam int unsigned SA = 3 * j;
        localparam int unsigned SB = 3 * j + 1;
        localparam int unsigned SC = 3 * j + 2;
        localparam logic [REM_W-1:0] K_LO = REM_W'(HORNER_DIV[j]);

        logic             vld_in;
        logic [X2_W-1:0]  x2_in;
        logic [COS_W-1:0] r_in;
        logic             tag_in;
        logic [31:0]      n_p;
        logic [31:0]      n_qe;
        logic [REM_W-1:0] qk_lo;
        logic [REM_W-1:0] rem_lo;
        logic             fix;
        logic [32:0]      diff;
        logic [COS_W-1:0] n_r;

        // The series starts from one; later steps take the previous result.
        if (j == 0) begin : g_first
            assign vld_in = i_in_valid;
            assign x2_in  = i_in_data.x2;
            assign r_in   = ONE_Q30;
            assign tag_in = i_in_data.outside;
        end else begin : g_next
            assign vld_in = r_vld[SA-1];
            assign x2_in  = r_x2[SA-1];
            assign r_in   = r_c_r[j-1];
            assign tag_in = r_tag[SA-1];
        end

        // Stage A: scale the running value by x squared.
        assign n_p = 32'((64'(x2_in) * 64'(r_in)) >> Q30_SHIFT);

        // Stage B: reciprocal multiply, an estimate at most one low.
        assign n_qe = 32'((64'(r_a_p[j]) * 64'(HORNER_RECIP[j])) >> HORNER_SHIFT[j]);

        // Stage C: the low remainder bits decide the correction, then the
        // result is one minus the quotient, clamped at zero.
        assign qk_lo  = r_b_qe[j][REM_W-1:0] * K_LO;
        assign rem_lo = r_b_p[j][REM_W-1:0] - qk_lo;
        assign fix    = rem_lo >= K_LO;
        assign diff   = {2'b00, ONE_Q30} - {1'b0, r_b_qe[j]} - 33'(fix);
        assign n_r    = diff[32] ? '0 : diff[COS_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[SA] <= 1'b0;
                r_vld[SB] <= 1'b0;
                r_vld[SC] <= 1'b0;
            end else begin
                if (stg_rdy[SA]) begin
                    r_vld[SA] <= vld_in;
                end
                if (stg_rdy[SB]) begin
                    r_vld[SB] <= r_vld[SA];
                end
                if (stg_rdy[SC]) begin
                    r_vld[SC] <= r_vld[SB];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_rdy[SA] && vld_in) begin
                r_a_p[j]  <= n_p;
                r_x2[SA]  <= x2_in;
                r_tag[SA] <= tag_in;
            end
            if (stg_rdy[SB] && r_vld[SA]) begin
                r_b_p[j]  <= r_a_p[j];
                r_b_qe[j] <= n_qe;
                r_x2[SB]  <= r_x2[SA];
                r_tag[SB] <= r_tag[SA];
            end
            if (stg_rdy[SC] && r_vld[SB]) begin
                r_c_r[j]  <= n_r;
                r_x2[SC]  <= r_x2[SB];
                r_tag[SC] <= r_tag[SB];
            end
        end
    end

    assign o_out_valid        = r_vld[HORNER_STAGES-1];
    assign o_out_data.c       = r_c_r[HORNER_STEPS-1];
    assign o_out_data.outside = r_tag[HORNER_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/raised_cosine_membership.sv
// ----------------------------------------------------------------------------
// Raised-cosine membership function
// Fuzzifies Q8.8 samples into a Q1.15 raised-cosine membership degree.
//
//   Channel    Dir   Payload               Notes
//   i_sample   in    sample  s16 Q8.8      one request per sample
//   o_degree   out   degree  u16 Q1.15     one result per request, in order
//   i_cfg      in    index u2, data u16    center, width, height; always ready
//
// One request per cycle sustained while o_degree is not stalled.
// The depth is set by the one-bit-per-stage phase divider and the seven
// three-stage Horner steps of the cosine unit.
// Reset restores center 0, width 1.0 and height 1.0 and empties the pipeline.
// Each stage holds while its successor is full and stalled, so bubbles close
// up under back-pressure and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raised_cosine_membership_assert.svh"

module raised_cosine_membership (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rcm_cfg_if.sink       i_cfg,
    rcm_sample_if.sink    i_sample,
    rcm_degree_if.source  o_degree
);
    import rcm_pkg::*;

    logic [CFG_DATA_W-1:0] r_center;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;

    logic                 r1_vld;
    logic signed [16:0]   r1_d;
    logic                 r2_vld;
    t_div_in              r2_div;
    logic                 r3_vld;
    logic [THETA_W-1:0]   r3_theta;
    logic                 r3_out;
    logic                 r4_vld;
    t_cos_in              r4_cos;
    logic                 r5_vld;
    logic [COS_W-1:0]     r5_c2;
    logic                 r5_out;
    logic                 r6_vld;
    logic [DEGREE_W-1:0]  r6_deg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic div_in_rdy, div_out_vld;
    logic cos_in_rdy, cos_out_vld;
    t_div_out div_out;
    t_cos_out cos_out;

    logic signed [16:0]       n_d;
    logic [16:0]              mag;
    t_div_in                  n_div;
    logic [THETA_W-1:0]       n_theta;
    logic [X2_W-1:0]          n_x2;
    logic [COS_W-1:0]         n_c2;
    logic [DEG_PROD_W-1:0]    deg_prod;
    logic [DEGREE_W-1:0]      n_deg;

    // Configuration writes; a zero width is stored as WIDTH_MIN, one LSB.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CENTER: begin
                    r_center <= i_cfg.data;
                end
                CFG_WIDTH: begin
                    r_width <= (i_cfg.data == '0) ? WIDTH_MIN : i_cfg.data;
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Ready chain from the output register back to the input.
    assign rdy6 = !r6_vld || o_degree.ready;
    assign rdy5 = !r5_vld || rdy6;
    assign rdy4 = !r4_vld || cos_in_rdy;
    assign rdy3 = !r3_vld || rdy4;
    assign rdy2 = !r2_vld || div_in_rdy;
    assign rdy1 = !r1_vld || rdy2;
    assign i_sample.ready = rdy1;

    // Stage 1: offset from the center, exact.
    assign n_d = {i_sample.sample[SAMPLE_W-1], i_sample.sample}
               - $signed({r_center[CFG_DATA_W-1], r_center});

    // Stage 2: magnitude, window test and the rounded phase division request.
    assign mag           = r1_d[16] ? 17'(-r1_d) : 17'(r1_d);
    assign n_div.outside = {mag, 1'b0} > {2'b00, r_width};
    assign n_div.num     = DIV_NUM_W'({mag[14:0], {(PHASE_BITS + 1){1'b0}}})
                         + DIV_NUM_W'(r_width);
    assign n_div.den     = {r_width, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_vld <= i_sample.valid;
            end
            if (rdy2) begin
                r2_vld <= r1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_sample.valid) begin
            r1_d <= n_d;
        end
        if (rdy2 && r1_vld) begin
            r2_div <= n_div;
        end
    end

    rcm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r2_vld),
        .o_in_ready  (div_in_rdy),
        .i_in_data   (r2_div),
        .o_out_valid (div_out_vld),
        .i_out_ready (rdy3),
        .o_out_data  (div_out)
    );

    // Stage 3: phase in half turns to angle, pi times the phase in Q2.30.
    assign n_theta = THETA_W'((THETA_PROD_W'(PI_Q30) * THETA_PROD_W'(div_out.quot))
                              >> PHASE_BITS);

    // Stage 4: angle squared for the series.
    assign n_x2 = X2_W'((64'(r3_theta) * 64'(r3_theta)) >> Q30_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy3) begin
                r3_vld <= div_out_vld;
            end
            if (rdy4) begin
                r4_vld <= r3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && div_out_vld) begin
            r3_theta <= n_theta;
            r3_out   <= div_out.outside;
        end
        if (rdy4 && r3_vld) begin
            r4_cos.x2      <= n_x2;
            r4_cos.outside <= r3_out;
        end
    end

    rcm_cos u_cos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r4_vld),
        .o_in_ready  (cos_in_rdy),
        .i_in_data   (r4_cos),
        .o_out_valid (cos_out_vld),
        .i_out_ready (rdy5),
        .o_out_data  (cos_out)
    );

    // Stage 5: cosine squared.
    assign n_c2 = COS_W'((64'(cos_out.c) * 64'(cos_out.c)) >> Q30_SHIFT);

    // Stage 6: scale by height with rounding; zero outside the window.
    assign deg_prod = DEG_PROD_W'(r_height) * DEG_PROD_W'(r5_c2) + DEG_PROD_W'(HALF_Q30);
    assign n_deg    = r5_out ? '0 : deg_prod[Q30_SHIFT +: DEGREE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            if (rdy5) begin
                r5_vld <= cos_out_vld;
            end
            if (rdy6) begin
                r6_vld <= r5_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && cos_out_vld) begin
            r5_c2  <= n_c2;
            r5_out <= cos_out.outside;
        end
        if (rdy6 && r5_vld) begin
            r6_deg <= n_deg;
        end
    end

    assign o_degree.valid  = r6_vld;
    assign o_degree.degree = r6_deg;

    // Checks on the datapath bounds and the width guard.
    `RCM_ASSERT_IMP(a_quot_bound, i_clk, i_rst_n, div_out_vld && !div_out.outside, div_out.quot <= QUOT_MAX)
    `RCM_ASSERT_IMP(a_cos_bound, i_clk, i_rst_n, cos_out_vld, cos_out.c <= ONE_Q30)
    `RCM_ASSERT_NXT(a_width_zero, i_clk, i_rst_n, i_cfg.valid && i_cfg.index == CFG_WIDTH && i_cfg.data == '0, r_width == WIDTH_MIN)

endmodule

`default_nettype wire
